[rtl/hqv_pkg.sv]
// Shared types, sizes and codes for the hash quorum voter.
// No dependencies; used by hqv_ctrl, hqv_dpath and hash_quorum_voter_unit.
package hqv_pkg;

    // Number of reporting sources per probe (2 to 8)
    localparam int NUM_SOURCES = 3;

    localparam int HASH_W      = 256;
    localparam int WORD_W      = 64;
    localparam int HEIGHT_W    = 31;
    localparam int QUORUM_W    = 4;
    localparam int AGREE_W     = 4;
    localparam int IDX_OUT_W   = 3;
    localparam int VERDICT_W   = 2;

    localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SEEN_W = $clog2(NUM_SOURCES + 1);
    localparam int CNT_W  = SEEN_W;

    // Stream word layout
    localparam int S_DATA_BITS = HEIGHT_W + HASH_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;
    localparam int M_DATA_BITS = HEIGHT_W + AGREE_W + IDX_OUT_W + HASH_W
                                 + 2 * IDX_OUT_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W   = VERDICT_W + 1;

    typedef logic [SRC_W-1:0]       src_t;
    typedef logic [SEEN_W-1:0]      seen_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [AGREE_W-1:0]     agree_t;
    typedef logic [IDX_OUT_W-1:0]   idx_out_t;
    typedef logic [QUORUM_W-1:0]    quorum_t;
    typedef logic [HASH_W-1:0]      hash_t;
    typedef logic [HEIGHT_W-1:0]    height_t;
    typedef logic [VERDICT_W-1:0]   verdict_t;

    localparam quorum_t DEFAULT_QUORUM = 4'd2;

    localparam verdict_t VERDICT_NO_DATA = 2'd0;
    localparam verdict_t VERDICT_MATCH   = 2'd1;
    localparam verdict_t VERDICT_SPLIT   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_TALLY,
        ST_FETCH,
        ST_EMIT
    } hqv_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;   // take the input word
        logic scan_read;   // read stored hash at the scan index
        logic scan_next;   // compare and advance the scan
        logic tally;       // count the report in its group
        logic fetch_best;  // read the winning hash
        logic emit;        // load the result and clear the probe
    } hqv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_need;   // incoming report must be compared with earlier ones
        logic hit;         // scanned source holds the same hash
        logic scan_end;    // scan index is the last earlier source
        logic item_last;   // loaded report closes the probe
        logic out_free;    // result register can take a new result
    } hqv_sts_t;

endpackage

[rtl/hash_quorum_voter_unit.sv]
// Hash quorum voter: one report per word, one verdict word per probe.
// Each present, error-free report is compared with the earlier stored hashes, at most its
// source index of them, one at a time, until the first equal one is found or the scan ends.
// The verdict is registered once the closing report has passed its scan, TALLY, FETCH
// and EMIT; it waits longer only while the previous verdict still waits for m_tready.
// Reset (aresetn low, synchronous) empties the probe, drops the result and sets
// the quorum threshold to 2. Top level; depends on hqv_pkg, hqv_ctrl and hqv_dpath.
module hash_quorum_voter_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Report words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // height, hash_word_0, hash_word_1, hash_word_2, hash_word_3, zero pad
    input  logic [hqv_pkg::S_TDATA_W-1:0]      s_tdata,
    // present, error
    input  logic [hqv_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                               s_tlast,
    // Verdict words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // probe_height, group_size, winner_source, winner_word_0..3,
    // split_first, split_second, zero pad
    output logic [hqv_pkg::M_TDATA_W-1:0]      m_tdata,
    // verdict, split_found
    output logic [hqv_pkg::M_TUSER_W-1:0]      m_tuser,
    // quorum threshold write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hqv_pkg::QUORUM_W-1:0]       cfg_data
);

    hqv_pkg::hqv_cmd_t cmd;
    hqv_pkg::hqv_sts_t sts;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    hqv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hqv_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

[rtl/hqv_ctrl.sv]
// Controller state machine of the hash quorum voter.
// Depends on hqv_pkg; drives hqv_dpath through hqv_cmd_t, reads hqv_sts_t.
module hqv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hqv_pkg::hqv_sts_t sts,
    output hqv_pkg::hqv_cmd_t cmd
);

    hqv_pkg::hqv_state_t state_reg;
    hqv_pkg::hqv_state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hqv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through scan, tally and result
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hqv_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.scan_need ? hqv_pkg::ST_READ : hqv_pkg::ST_TALLY;
                end
            end
            hqv_pkg::ST_READ: begin
                state_next = hqv_pkg::ST_CMP;
            end
            hqv_pkg::ST_CMP: begin
                if (sts.hit || sts.scan_end) begin
                    state_next = hqv_pkg::ST_TALLY;
                end else begin
                    state_next = hqv_pkg::ST_READ;
                end
            end
            hqv_pkg::ST_TALLY: begin
                state_next = sts.item_last ? hqv_pkg::ST_FETCH : hqv_pkg::ST_IDLE;
            end
            hqv_pkg::ST_FETCH: begin
                state_next = hqv_pkg::ST_EMIT;
            end
            hqv_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = hqv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hqv_pkg::ST_IDLE;
            end
        endcase
    end

    // Decode commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            hqv_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            hqv_pkg::ST_READ: begin
                cmd.scan_read = 1'b1;
            end
            hqv_pkg::ST_CMP: begin
                cmd.scan_next = 1'b1;
            end
            hqv_pkg::ST_TALLY: begin
                cmd.tally = 1'b1;
            end
            hqv_pkg::ST_FETCH: begin
                cmd.fetch_best = 1'b1;
            end
            hqv_pkg::ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/hqv_dpath.sv]
// Datapath of the hash quorum voter: hash memory, group tallies, result register.
// Depends on hqv_pkg; commanded by hqv_ctrl.
module hqv_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input word
    input  logic [hqv_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [hqv_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                               s_tlast,
    // Configuration
    input  logic                               cfg_wr,
    input  logic [hqv_pkg::QUORUM_W-1:0]       cfg_data,
    // Result word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hqv_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [hqv_pkg::M_TUSER_W-1:0]      m_tuser,
    // Controller link
    input  hqv_pkg::hqv_cmd_t                  cmd,
    output hqv_pkg::hqv_sts_t                  sts
);

    // Input word fields
    hqv_pkg::height_t in_height;
    hqv_pkg::hash_t   in_hash;
    logic             in_present;
    logic             in_error;

    assign in_height  = s_tdata[hqv_pkg::HEIGHT_W-1:0];
    assign in_hash    = s_tdata[hqv_pkg::S_DATA_BITS-1:hqv_pkg::HEIGHT_W];
    assign in_present = s_tuser[0];
    assign in_error   = s_tuser[1];

    // Probe state
    hqv_pkg::quorum_t           quorum_reg;
    hqv_pkg::seen_t             seen_reg;
    logic [hqv_pkg::NUM_SOURCES-1:0] counted_reg;
    hqv_pkg::cnt_t              counts_reg [hqv_pkg::NUM_SOURCES];
    hqv_pkg::cnt_t              best_cnt_reg;
    hqv_pkg::src_t              best_idx_reg;
    logic                       any_reg;
    logic                       have_a_reg;
    hqv_pkg::src_t              a_reg;
    logic                       split_reg;
    hqv_pkg::src_t              second_reg;

    // Current report
    hqv_pkg::hash_t             hash_reg;
    hqv_pkg::height_t           height_reg;
    hqv_pkg::src_t              slot_reg;
    logic                       cnt_item_reg;
    logic                       last_reg;
    hqv_pkg::src_t              j_reg;
    hqv_pkg::src_t              lead_reg;

    // Hash memory
    hqv_pkg::hash_t             hash_mem [hqv_pkg::NUM_SOURCES];
    hqv_pkg::hash_t             rd_data_reg;
    hqv_pkg::src_t              rd_addr;

    // Result register
    logic                       m_valid_reg;
    hqv_pkg::height_t           out_height_reg;
    hqv_pkg::verdict_t          out_verdict_reg;
    hqv_pkg::agree_t            out_agree_reg;
    hqv_pkg::idx_out_t          out_winner_reg;
    hqv_pkg::hash_t             out_hash_reg;
    logic                       out_split_reg;
    hqv_pkg::idx_out_t          out_first_reg;
    hqv_pkg::idx_out_t          out_second_reg;

    logic                       room;
    hqv_pkg::src_t              in_slot;
    logic                       in_counted;
    hqv_pkg::cnt_t              inc_cnt;
    logic                       better;
    hqv_pkg::quorum_t           need;
    logic                       is_match;
    hqv_pkg::verdict_t          verdict;

    assign room       = seen_reg < hqv_pkg::seen_t'(hqv_pkg::NUM_SOURCES);
    assign in_slot    = seen_reg[hqv_pkg::SRC_W-1:0];
    assign in_counted = room && in_present && !in_error;

    // Status to controller
    assign sts.scan_need = in_counted && (seen_reg != '0);
    assign sts.hit       = counted_reg[j_reg] && (rd_data_reg == hash_reg);
    assign sts.scan_end  = (hqv_pkg::seen_t'(j_reg) + hqv_pkg::seen_t'(1))
                           == hqv_pkg::seen_t'(slot_reg);
    assign sts.item_last = last_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

    // Group tally and tie break toward the earlier leader
    assign inc_cnt = counts_reg[lead_reg] + hqv_pkg::cnt_t'(1);
    assign better  = (inc_cnt > best_cnt_reg)
                     || ((inc_cnt == best_cnt_reg) && (lead_reg < best_idx_reg));

    // Verdict
    assign need     = (quorum_reg == '0) ? hqv_pkg::DEFAULT_QUORUM : quorum_reg;
    assign is_match = hqv_pkg::quorum_t'(best_cnt_reg) >= need;
    always_comb begin
        if (!any_reg) begin
            verdict = hqv_pkg::VERDICT_NO_DATA;
        end else if (is_match) begin
            verdict = hqv_pkg::VERDICT_MATCH;
        end else begin
            verdict = hqv_pkg::VERDICT_SPLIT;
        end
    end

    // Write the report hash, read at scan or winner index
    assign rd_addr = cmd.fetch_best ? best_idx_reg : j_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load_item && room) begin
            hash_mem[in_slot] <= in_hash;
        end
        if (cmd.scan_read || cmd.fetch_best) begin
            rd_data_reg <= hash_mem[rd_addr];
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quorum_reg <= hqv_pkg::DEFAULT_QUORUM;
        end else if (cfg_wr) begin
            quorum_reg <= cfg_data;
        end
    end

    // Capture the current report and run the scan
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            hash_reg     <= in_hash;
            height_reg   <= in_height;
            slot_reg     <= in_slot;
            cnt_item_reg <= in_counted;
            last_reg     <= s_tlast;
            j_reg        <= '0;
            lead_reg     <= in_slot;
        end else if (cmd.scan_next) begin
            j_reg <= j_reg + hqv_pkg::src_t'(1);
            if (sts.hit) begin
                lead_reg <= j_reg;
            end
        end
    end

    // Probe state: fill on load, tally, clear on result
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            seen_reg     <= '0;
            counted_reg  <= '0;
            best_cnt_reg <= '0;
            best_idx_reg <= '0;
            any_reg      <= 1'b0;
            have_a_reg   <= 1'b0;
            split_reg    <= 1'b0;
            a_reg        <= '0;
            second_reg   <= '0;
            for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            if (cmd.load_item && room) begin
                seen_reg             <= seen_reg + hqv_pkg::seen_t'(1);
                counted_reg[in_slot] <= in_present && !in_error;
            end
            if (cmd.tally && cnt_item_reg) begin
                counts_reg[lead_reg] <= inc_cnt;
                any_reg              <= 1'b1;
                if (better) begin
                    best_cnt_reg <= inc_cnt;
                    best_idx_reg <= lead_reg;
                end
                if (!have_a_reg) begin
                    have_a_reg <= 1'b1;
                    a_reg      <= slot_reg;
                end else if (!split_reg && (lead_reg != a_reg)) begin
                    split_reg  <= 1'b1;
                    second_reg <= slot_reg;
                end
            end
        end
    end

    // Result valid: set on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_height_reg  <= height_reg;
            out_verdict_reg <= verdict;
            out_agree_reg   <= hqv_pkg::agree_t'(best_cnt_reg);
            if (verdict == hqv_pkg::VERDICT_MATCH) begin
                out_winner_reg <= hqv_pkg::idx_out_t'(best_idx_reg);
                out_hash_reg   <= rd_data_reg;
            end else begin
                out_winner_reg <= '0;
                out_hash_reg   <= '0;
            end
            if ((verdict == hqv_pkg::VERDICT_SPLIT) && split_reg) begin
                out_split_reg  <= 1'b1;
                out_first_reg  <= hqv_pkg::idx_out_t'(a_reg);
                out_second_reg <= hqv_pkg::idx_out_t'(second_reg);
            end else begin
                out_split_reg  <= 1'b0;
                out_first_reg  <= '0;
                out_second_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(hqv_pkg::M_TDATA_W - hqv_pkg::M_DATA_BITS){1'b0}},
                       out_second_reg, out_first_reg, out_hash_reg,
                       out_winner_reg, out_agree_reg, out_height_reg};
    assign m_tuser  = {out_split_reg, out_verdict_reg};

    // Never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("result overwritten while pending");

    // A group leader is never later than the report it counts
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tally && cnt_item_reg) |-> (lead_reg <= slot_reg))
        else $error("group leader after reporting source");

    // Largest group cannot exceed reports taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        hqv_pkg::seen_t'(best_cnt_reg) <= seen_reg)
        else $error("group size exceeds reports taken");

    // A differing pair needs a first counted source
    assert property (@(posedge aclk) disable iff (!aresetn)
        split_reg |-> (have_a_reg && any_reg))
        else $error("split pair without first source");

endmodule

[sim/tb_hash_quorum_voter_unit.sv]
// Self-checking testbench for hash_quorum_voter_unit: directed probes, then
// random probes under several sender and receiver idling mixes.
// Depends on hqv_pkg and the hash_quorum_voter_unit RTL.
`timescale 1ns / 1ps

module tb_hash_quorum_voter_unit;

    // Cycles the block may still be busy after its last verdict word
    localparam int LATENCY = 2 * hqv_pkg::NUM_SOURCES + 8;

    typedef logic [hqv_pkg::NUM_SOURCES-1:0] src_mask_t;

    // Report word: height, hash_word_0..3, zero pad (lowest bits first)
    typedef struct packed {
        logic [hqv_pkg::S_TDATA_W-hqv_pkg::S_DATA_BITS-1:0] pad;
        hqv_pkg::hash_t                                     hash;
        hqv_pkg::height_t                                   height;
    } report_word_t;

    // Verdict word: probe_height, group_size, winner_source,
    // winner_word_0..3, split_first, split_second, zero pad
    typedef struct packed {
        logic [hqv_pkg::M_TDATA_W-hqv_pkg::M_DATA_BITS-1:0] pad;
        hqv_pkg::idx_out_t                                  split_second;
        hqv_pkg::idx_out_t                                  split_first;
        hqv_pkg::hash_t                                     winner_hash;
        hqv_pkg::idx_out_t                                  winner_src;
        hqv_pkg::agree_t                                    agreeing;
        hqv_pkg::height_t                                   height;
    } verdict_word_t;

    typedef struct {
        hqv_pkg::height_t height;
        logic             present;
        logic             error;
        hqv_pkg::hash_t   hash;
        logic             last;
    } report_t;

    typedef struct {
        hqv_pkg::height_t  height;
        hqv_pkg::verdict_t verdict;
        hqv_pkg::agree_t   agreeing;
        hqv_pkg::idx_out_t winner_src;
        hqv_pkg::hash_t    winner_hash;
        logic              split_found;
        hqv_pkg::idx_out_t split_first;
        hqv_pkg::idx_out_t split_second;
    } verdict_rec_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [hqv_pkg::S_TDATA_W-1:0]   s_tdata;
    logic [hqv_pkg::S_TUSER_W-1:0]   s_tuser;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [hqv_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [hqv_pkg::M_TUSER_W-1:0]   m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [hqv_pkg::QUORUM_W-1:0]    cfg_data;

    hash_quorum_voter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Voter shadow state
    hqv_pkg::quorum_t shadow_quorum = hqv_pkg::DEFAULT_QUORUM;
    hqv_pkg::hash_t   shadow_hash [hqv_pkg::NUM_SOURCES];
    logic             shadow_counted [hqv_pkg::NUM_SOURCES];
    int               shadow_seen = 0;
    verdict_rec_t     pending_verdicts [$];

    int             idle_pct = 0;
    int             stall_pct = 0;
    int             error_count = 0;
    int             reports_sent = 0;
    hqv_pkg::hash_t probe_hash [hqv_pkg::NUM_SOURCES];

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("hash_quorum_voter_unit verification failed");
        $finish;
    end

    // Stall the verdict stream at random
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= stall_pct);
    end

    // Store one report and vote when it closes the probe
    task automatic tally_report(input report_t r);
        int           counts [hqv_pkg::NUM_SOURCES];
        int           total;
        int           best_cnt;
        int           best_src;
        int           need;
        int           first_src;
        bit           have_first;
        verdict_rec_t v;
        total = 0;
        best_cnt = 0;
        best_src = 0;
        first_src = 0;
        have_first = 0;
        if (shadow_seen < hqv_pkg::NUM_SOURCES) begin
            shadow_counted[shadow_seen] = r.present && !r.error;
            shadow_hash[shadow_seen] = r.hash;
            shadow_seen++;
        end
        if (!r.last) return;

        v.height = r.height;
        v.verdict = hqv_pkg::VERDICT_NO_DATA;
        v.agreeing = '0;
        v.winner_src = '0;
        v.winner_hash = '0;
        v.split_found = 1'b0;
        v.split_first = '0;
        v.split_second = '0;

        // Tally each group at its earliest counted member
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) counts[i] = 0;
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) begin
            if (!shadow_counted[i]) continue;
            total++;
            for (int j = 0; j <= i; j++) begin
                if (shadow_counted[j] && shadow_hash[j] == shadow_hash[i]) begin
                    counts[j]++;
                    break;
                end
            end
        end
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) begin
            if (counts[i] > best_cnt) begin
                best_cnt = counts[i];
                best_src = i;
            end
        end
        need = (shadow_quorum == 0) ? int'(hqv_pkg::DEFAULT_QUORUM) : int'(shadow_quorum);

        if (total == 0) begin
            v.verdict = hqv_pkg::VERDICT_NO_DATA;
        end else if (best_cnt >= need) begin
            v.verdict = hqv_pkg::VERDICT_MATCH;
            v.agreeing = hqv_pkg::agree_t'(best_cnt);
            v.winner_src = hqv_pkg::idx_out_t'(best_src);
            v.winner_hash = shadow_hash[best_src];
        end else begin
            v.verdict = hqv_pkg::VERDICT_SPLIT;
            v.agreeing = hqv_pkg::agree_t'(best_cnt);
            // Find the first counted source and the first later one that differs
            for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) begin
                if (!shadow_counted[i]) continue;
                if (!have_first) begin
                    have_first = 1;
                    first_src = i;
                end else if (shadow_hash[first_src] != shadow_hash[i]) begin
                    v.split_found = 1'b1;
                    v.split_first = hqv_pkg::idx_out_t'(first_src);
                    v.split_second = hqv_pkg::idx_out_t'(i);
                    break;
                end
            end
        end

        // Open a new probe
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) shadow_counted[i] = 1'b0;
        shadow_seen = 0;
        pending_verdicts.push_back(v);
    endtask

    function automatic int field_differs(input string name,
                                         input logic [hqv_pkg::HASH_W-1:0] exp_v,
                                         input logic [hqv_pkg::HASH_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // Compare each verdict word with the oldest prediction
    always @(posedge aclk) begin : check_verdicts
        verdict_rec_t  exp_v;
        verdict_word_t got;
        int            bad;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: verdict word with none expected, expected none actual %h %h",
                         $realtime, m_tuser, m_tdata);
                error_count++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                got = verdict_word_t'(m_tdata);
                bad = 0;
                bad += field_differs("probe_height", exp_v.height, got.height);
                bad += field_differs("verdict", exp_v.verdict,
                                     m_tuser[hqv_pkg::VERDICT_W-1:0]);
                bad += field_differs("group_size", exp_v.agreeing, got.agreeing);
                bad += field_differs("winner_source", exp_v.winner_src, got.winner_src);
                bad += field_differs("winner_hash", exp_v.winner_hash, got.winner_hash);
                bad += field_differs("split_found", exp_v.split_found,
                                     m_tuser[hqv_pkg::VERDICT_W]);
                bad += field_differs("split_first", exp_v.split_first, got.split_first);
                bad += field_differs("split_second", exp_v.split_second, got.split_second);
                bad += field_differs("tdata pad", '0, got.pad);
                if (bad != 0) error_count++;
            end
        end
    end

    // Send one report word; entered and left just after a falling edge
    task automatic send_report(input report_t r);
        report_word_t w;
        w.pad = '0;
        w.hash = r.hash;
        w.height = r.height;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = w;
        s_tuser = {r.error, r.present};
        s_tlast = r.last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        tally_report(r);
        reports_sent++;
        @(negedge aclk);
    endtask

    // Hold the sender until no verdict is outstanding, then wait extra cycles
    task automatic wait_drained(input int extra);
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_quorum(input hqv_pkg::quorum_t value);
        wait_drained(LATENCY);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        shadow_quorum = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Send one full probe from probe_hash with per-source present and error masks
    task automatic send_probe(input hqv_pkg::height_t ht, input src_mask_t pres,
                              input src_mask_t err);
        report_t r;
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) begin
            r.height = ht;
            r.present = pres[i];
            r.error = err[i];
            r.hash = probe_hash[i];
            r.last = (i == hqv_pkg::NUM_SOURCES - 1);
            send_report(r);
        end
    endtask

    function automatic hqv_pkg::hash_t rand_hash();
        hqv_pkg::hash_t h;
        for (int i = 0; i < hqv_pkg::HASH_W / 32; i++) h[i*32 +: 32] = $urandom;
        return h;
    endfunction

    task automatic test_no_data();
        // Mix absent, errored, and absent-with-error sources
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) probe_hash[i] = rand_hash();
        send_probe(hqv_pkg::height_t'(12345), {{(hqv_pkg::NUM_SOURCES-1){1'b0}}, 1'b1},
                   {{(hqv_pkg::NUM_SOURCES-2){1'b1}}, 2'b01});
    endtask

    task automatic test_full_match();
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) probe_hash[i] = '1;
        send_probe('1, '1, '0);
    endtask

    task automatic test_plurality();
        hqv_pkg::hash_t a;
        hqv_pkg::hash_t b;
        a = rand_hash();
        b = a;
        b[255:192] = ~a[255:192];
        // Alternate two hashes that differ only in the top word
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) probe_hash[i] = (i % 2 == 0) ? a : b;
        send_probe(hqv_pkg::height_t'($urandom), '1, '0);
        // All hashes distinct: no group reaches two
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) probe_hash[i] = a ^ hqv_pkg::hash_t'(i);
        send_probe(hqv_pkg::height_t'($urandom), '1, '0);
    endtask

    task automatic test_lone_source();
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) probe_hash[i] = rand_hash();
        send_probe(hqv_pkg::height_t'($urandom), '1, ~src_mask_t'(2));
    endtask

    task automatic test_surplus_reports();
        report_t r;
        // Reports past the source count must not disturb the stored hashes
        for (int i = 0; i <= hqv_pkg::NUM_SOURCES; i++) begin
            r.height = (i == hqv_pkg::NUM_SOURCES) ? hqv_pkg::height_t'(0)
                                                   : hqv_pkg::height_t'($urandom);
            r.present = 1'b1;
            r.error = 1'b0;
            r.hash = (i < hqv_pkg::NUM_SOURCES) ? hqv_pkg::hash_t'(0) : rand_hash();
            r.last = (i == hqv_pkg::NUM_SOURCES);
            send_report(r);
        end
    endtask

    task automatic test_short_probe();
        report_t r;
        r.height = hqv_pkg::height_t'($urandom);
        r.present = 1'b1;
        r.error = 1'b0;
        r.hash = rand_hash();
        r.last = 1'b1;
        send_report(r);
    endtask

    task automatic test_thresholds();
        hqv_pkg::hash_t a;
        a = rand_hash();
        // Zero threshold falls back to the default of two
        write_quorum('0);
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) probe_hash[i] = (i < 2) ? a : ~a;
        send_probe(hqv_pkg::height_t'($urandom), '1, '0);
        // Threshold above the source count can only split
        write_quorum('1);
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) probe_hash[i] = a;
        send_probe(hqv_pkg::height_t'($urandom), '1, '0);
        // Threshold of one matches on a lone distinct hash
        write_quorum(hqv_pkg::quorum_t'(1));
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) begin
            probe_hash[i] = a ^ hqv_pkg::hash_t'(i + 1);
        end
        send_probe(hqv_pkg::height_t'($urandom), '1, '0);
        write_quorum(hqv_pkg::quorum_t'(8));
        write_quorum(hqv_pkg::DEFAULT_QUORUM);
    endtask

    // One random probe: mostly well formed, some short or overlong
    task automatic rand_probe();
        hqv_pkg::hash_t pool [3];
        report_t        r;
        int             kind;
        int             n_reports;
        int             pick;
        pool[0] = rand_hash();
        pool[1] = rand_hash();
        pool[2] = rand_hash();
        // Now and then make a near miss that differs from pool[0] in one word
        if ($urandom_range(0, 3) == 0) begin
            pool[1] = pool[0];
            pool[1][$urandom_range(0, 3)*64 +: 64] = ~pool[0][$urandom_range(0, 3)*64 +: 64];
        end
        kind = $urandom_range(0, 99);
        if (kind < 80) n_reports = hqv_pkg::NUM_SOURCES;
        else if (kind < 90) n_reports = $urandom_range(1, hqv_pkg::NUM_SOURCES - 1);
        else n_reports = $urandom_range(hqv_pkg::NUM_SOURCES + 1, hqv_pkg::NUM_SOURCES + 3);
        if ($urandom_range(0, 99) < 3) wait_drained(0);
        for (int i = 0; i < n_reports; i++) begin
            pick = $urandom_range(0, 99);
            r.height = hqv_pkg::height_t'($urandom);
            r.present = ($urandom_range(0, 99) < 90);
            r.error = ($urandom_range(0, 99) < 12);
            r.hash = (pick < 45) ? pool[0] : (pick < 70) ? pool[1] :
                     (pick < 85) ? pool[2] : rand_hash();
            r.last = (i == n_reports - 1);
            send_report(r);
        end
    endtask

    task automatic run_random_phase(input int idle, input int stall,
                                    input hqv_pkg::quorum_t cfg_a,
                                    input hqv_pkg::quorum_t cfg_b, input int count);
        int target;
        idle_pct = idle;
        stall_pct = stall;
        write_quorum(cfg_a);
        target = reports_sent + count;
        while (reports_sent < target) rand_probe();
        write_quorum(cfg_b);
        target = reports_sent + count;
        while (reports_sent < target) rand_probe();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < hqv_pkg::NUM_SOURCES; i++) begin
            shadow_counted[i] = 1'b0;
            shadow_hash[i] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_no_data();
        test_full_match();
        test_plurality();
        test_lone_source();
        test_surplus_reports();
        test_short_probe();
        test_thresholds();

        run_random_phase(0, 0, hqv_pkg::DEFAULT_QUORUM, hqv_pkg::quorum_t'(1), 110);
        run_random_phase(75, 0, hqv_pkg::quorum_t'(hqv_pkg::NUM_SOURCES), '0, 110);
        run_random_phase(0, 75, '1, hqv_pkg::quorum_t'(8), 110);
        run_random_phase(11, 11, hqv_pkg::quorum_t'(1), hqv_pkg::DEFAULT_QUORUM, 110);

        // Drain and let the block settle
        wait_drained(LATENCY);
        if (error_count == 0) begin
            $display("hash_quorum_voter_unit verification clean");
        end else begin
            $display("hash_quorum_voter_unit verification failed");
        end
        $finish;
    end

endmodule
